// File: design/audio_distortion_waveshaper_unit_macros.svh
// Assertion macros for the waveshaper block.
`ifndef AUDIO_DISTORTION_WAVESHAPER_UNIT_MACROS_SVH
`define AUDIO_DISTORTION_WAVESHAPER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ADWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("waveshaper assertion failed");

// Next-cycle implication.
`define ADWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("waveshaper assertion failed");

`else

`define ADWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ADWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/adws_pkg.sv
// Shared constants and types for the waveshaper block.
`timescale 1ns / 1ps

package adws_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;

	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 12;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	localparam int MODE_W = 2;
	localparam logic [MODE_W-1:0] MODE_HARD     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SOFT     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FULLWAVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_HALFWAVE = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_SHAPER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN  = 2'd1;

	// Per-item flags travelling alongside the knee arithmetic.
	typedef struct packed {
		logic knee;
		logic neg;
	} shp_flags_t;

endpackage

// File: design/adws_stream_if.sv
// Valid/ready stream interfaces for input and result samples.
`timescale 1ns / 1ps

interface adws_in_if #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] in_sample;
	logic                           in_last;

	modport source (output valid, output in_sample, output in_last, input ready);
	modport sink   (input valid, input in_sample, input in_last, output ready);
endinterface

interface adws_out_if #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] out_sample;
	logic                           out_last;

	modport source (output valid, output out_sample, output out_last, input ready);
	modport sink   (input valid, input out_sample, input out_last, output ready);
endinterface

// File: design/audio_distortion_waveshaper_unit.sv
// Top level of the distortion waveshaper: config registers, pipeline control, output stage.
`timescale 1ns / 1ps
//
// Per-sample distortion. Samples arrive on in_chan (in_sample, in_last) and
// results leave on out_chan (out_sample, out_last); a transfer happens on a
// clock edge with valid and ready both high. in_last is carried unchanged.
// Config: cfg_wr_en with cfg_index 0 writes shaper_mode (hard clip, soft
// clip, full-wave, half-wave), index 1 writes the Q4.12 drive_gain; other
// indexes are dropped. Only write while no sample is in flight.
// Pipeline: eight register stages lie between the input transfer and
// out_chan.valid (multiply, round, magnitude, region split, square,
// subtract, reciprocal multiply, output register).
// Throughput: one sample per cycle while out_chan.ready stays high, set by
// the single gain multiplier and the two knee multipliers, each pipelined.
// Reset (arst_n low): all stage valids clear, mode = hard clip, gain = 1.0.
// Receiver stall: each stage holds while the next is full and stalled;
// empty stages keep filling, so in_chan.ready only drops once all eight
// stages hold a sample.
//
`include "audio_distortion_waveshaper_unit_macros.svh"

module audio_distortion_waveshaper_unit #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [adws_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adws_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	adws_in_if.sink                              in_chan,
	adws_out_if.source                           out_chan
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int F  = W - 1;
	localparam int XW = W + adws_pkg::GAIN_W - adws_pkg::GAIN_FRAC + 1;
	localparam int NS = 8;
	localparam int REM0 = (F % 2 == 0) ? 1 : 2;
	// floor(ONE/3), base of the knee quotient
	localparam logic [63:0]  C64     = ((64'd1 << F) - 64'(REM0)) / 64'd3;
	localparam logic [F-1:0] C_THIRD = C64[F-1:0];

	// config registers
	logic [adws_pkg::MODE_W-1:0] mode_q;
	logic [adws_pkg::GAIN_W-1:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= adws_pkg::MODE_HARD;
			gain_q <= adws_pkg::GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				adws_pkg::CFG_SHAPER_MODE: mode_q <= cfg_wdata[adws_pkg::MODE_W-1:0];
				adws_pkg::CFG_DRIVE_GAIN:  gain_q <= cfg_wdata[adws_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage control: a stage loads when it is empty or the next one moves
	logic [NS:1] vld_s;
	logic [NS:1] last_s;
	logic [NS:1] en;

	always_comb begin
		en[NS] = !vld_s[NS] || out_chan.ready;
		for (int i = NS - 1; i >= 1; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign in_chan.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= in_chan.valid;
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// end-of-block marker rides alongside the data
	always_ff @(posedge clk) begin
		if (en[1]) last_s[1] <= in_chan.in_last;
		for (int i = 2; i <= NS; i++) begin
			if (en[i]) last_s[i] <= last_s[i-1];
		end
	end

	// datapath
	logic signed [XW-1:0]       x_s2;
	logic signed [W-1:0]        y_s4, y_s7;
	logic [F-1:0]               u_s4;
	logic [2*F-1:0]             nm_s7;
	adws_pkg::shp_flags_t       flags_s4, flags_s7;

	adws_drive #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_drive (
		.clk    (clk),
		.en     (en[2:1]),
		.sample (in_chan.in_sample),
		.gain   (gain_q),
		.x_s2   (x_s2)
	);

	adws_shape #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_shape (
		.clk      (clk),
		.en       (en[4:3]),
		.mode     (mode_q),
		.x        (x_s2),
		.y_s4     (y_s4),
		.u_s4     (u_s4),
		.flags_s4 (flags_s4)
	);

	adws_knee #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_knee (
		.clk      (clk),
		.en       (en[7:5]),
		.u_s4     (u_s4),
		.y_s4     (y_s4),
		.flags_s4 (flags_s4),
		.nm_s7    (nm_s7),
		.y_s7     (y_s7),
		.flags_s7 (flags_s7)
	);

	// knee magnitude = ONE/3 rounded down plus the offset quotient
	logic [F-1:0]        knee_mag;
	logic signed [W-1:0] knee_val;
	logic signed [W-1:0] out_sample_s8;

	assign knee_mag = C_THIRD + {1'b0, nm_s7[2*F-1:F+1]};
	assign knee_val = flags_s7.neg ? -$signed({1'b0, knee_mag}) : $signed({1'b0, knee_mag});

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			out_sample_s8 <= flags_s7.knee ? knee_val : y_s7;
		end
	end

	assign out_chan.valid      = vld_s[NS];
	assign out_chan.out_sample = out_sample_s8;
	assign out_chan.out_last   = last_s[NS];

	// checks
	`ADWS_ASSERT_NOW(a_ready_only_when_full, clk, arst_n, !in_chan.ready, &vld_s)
	`ADWS_ASSERT_NOW(a_knee_only_soft, clk, arst_n, vld_s[7] && flags_s7.knee, mode_q == adws_pkg::MODE_SOFT)
	`ADWS_ASSERT_NEXT(a_gain_write, clk, arst_n, cfg_wr_en && cfg_index == adws_pkg::CFG_DRIVE_GAIN, gain_q == $past(cfg_wdata))

endmodule

// File: design/adws_drive.sv
// Gain multiply and round-half-up back to sample precision (stages 1-2).
`timescale 1ns / 1ps

module adws_drive #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic [1:0]                                   en,
	input  logic signed [SAMPLE_WIDTH-1:0]               sample,
	input  logic [adws_pkg::GAIN_W-1:0]                  gain,
	output logic signed [SAMPLE_WIDTH+adws_pkg::GAIN_W-adws_pkg::GAIN_FRAC:0] x_s2
);

	localparam int PW = SAMPLE_WIDTH + adws_pkg::GAIN_W + 1;
	localparam logic signed [PW-1:0] ROUND = PW'(1) <<< (adws_pkg::GAIN_FRAC - 1);

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] rnd;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= PW'(sample) * PW'($signed({1'b0, gain}));
		end
	end

	assign rnd = prod_s1 + ROUND;

	// upper bits of a two's complement word give the floor
	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2 <= rnd[PW-1:adws_pkg::GAIN_FRAC];
		end
	end

endmodule

// File: design/adws_shape.sv
// Magnitude, region split and the non-knee shaper results (stages 3-4).
`timescale 1ns / 1ps

module adws_shape #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic [1:0]                                   en,
	input  logic [adws_pkg::MODE_W-1:0]                  mode,
	input  logic signed [SAMPLE_WIDTH+adws_pkg::GAIN_W-adws_pkg::GAIN_FRAC:0] x,
	output logic signed [SAMPLE_WIDTH-1:0]               y_s4,
	output logic [SAMPLE_WIDTH-2:0]                      u_s4,
	output adws_pkg::shp_flags_t                         flags_s4
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int F  = W - 1;
	localparam int XW = W + adws_pkg::GAIN_W - adws_pkg::GAIN_FRAC + 1;
	localparam int TW = XW + 2;

	localparam logic signed [XW-1:0] HALF_X  = XW'(1) <<< (F - 1);
	localparam logic signed [XW-1:0] NHALF_X = -HALF_X;
	localparam logic [XW-1:0]        MAX_X   = (XW'(1) << F) - XW'(1);
	localparam logic [TW-1:0]        ONE_T   = TW'(1) << F;
	localparam logic [TW-1:0]        TWO_T   = TW'(1) << (F + 1);
	localparam logic signed [W-1:0]  HALF_W  = W'(1) <<< (F - 1);
	localparam logic signed [W-1:0]  MAX_W   = W'((W'(1) << F) - W'(1));

	logic signed [XW-1:0] x_s3;
	logic [XW-1:0]        mag_s3;
	logic                 neg_s3;

	logic [TW-1:0]        m3;
	logic [TW-1:0]        u_full;
	logic                 lin, sat, big;
	logic signed [W-1:0]  y_nxt;
	adws_pkg::shp_flags_t flags_nxt;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s3   <= x;
			neg_s3 <= x[XW-1];
			mag_s3 <= x[XW-1] ? XW'(-x) : XW'(x);
		end
	end

	assign m3     = TW'(mag_s3) + {1'b0, mag_s3, 1'b0};
	assign lin    = m3 <= ONE_T;
	assign sat    = m3 > TWO_T;
	assign big    = mag_s3 > MAX_X;
	assign u_full = TWO_T - m3;

	always_comb begin
		flags_nxt.neg  = neg_s3;
		flags_nxt.knee = 1'b0;
		case (mode)
			adws_pkg::MODE_HARD: begin
				if (x_s3 > HALF_X) y_nxt = HALF_W;
				else if (x_s3 < NHALF_X) y_nxt = -HALF_W;
				else y_nxt = x_s3[W-1:0];
			end
			adws_pkg::MODE_SOFT: begin
				flags_nxt.knee = !lin && !sat;
				if (sat) y_nxt = neg_s3 ? -HALF_W : HALF_W;
				else y_nxt = x_s3[W-1:0];
			end
			adws_pkg::MODE_FULLWAVE: begin
				y_nxt = big ? MAX_W : $signed(mag_s3[W-1:0]);
			end
			adws_pkg::MODE_HALFWAVE: begin
				if (neg_s3 || mag_s3 == '0) y_nxt = '0;
				else y_nxt = big ? MAX_W : $signed(mag_s3[W-1:0]);
			end
			default: y_nxt = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			y_s4     <= y_nxt;
			u_s4     <= u_full[F-1:0];
			flags_s4 <= flags_nxt;
		end
	end

endmodule

// File: design/adws_knee.sv
// Soft-clip knee arithmetic: square, subtract, divide by three (stages 5-7).
`timescale 1ns / 1ps

module adws_knee #(
	parameter int SAMPLE_WIDTH = adws_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic [2:0]                         en,
	input  logic [SAMPLE_WIDTH-2:0]            u_s4,
	input  logic signed [SAMPLE_WIDTH-1:0]     y_s4,
	input  adws_pkg::shp_flags_t               flags_s4,
	output logic [2*(SAMPLE_WIDTH-1)-1:0]      nm_s7,
	output logic signed [SAMPLE_WIDTH-1:0]     y_s7,
	output adws_pkg::shp_flags_t               flags_s7
);

	localparam int F  = SAMPLE_WIDTH - 1;
	localparam int NW = 2 * F + 2;
	localparam int REM0 = (F % 2 == 0) ? 1 : 2;

	// 3*ONE^2 + 3*ONE
	localparam logic [NW-1:0] K_NUM = (NW'(3) << (2 * F)) + (NW'(3) << F);
	localparam logic [F:0]    ONE_Q = (F + 1)'(1) << F;
	localparam logic [F:0]    REM_Q = (F + 1)'(REM0);
	// ceil(2^(F+1)/3): exact floor(n/3) for any n below 2^F
	localparam logic [63:0]   M64   = ((64'd1 << (F + 1)) + ((F % 2 == 1) ? 64'd2 : 64'd1)) / 64'd3;
	localparam logic [F-1:0]  RECIP = M64[F-1:0];

	logic [2*F-1:0]       u2_s5;
	logic [F-1:0]         n_s6;
	logic signed [SAMPLE_WIDTH-1:0] y_s5, y_s6;
	adws_pkg::shp_flags_t flags_s5, flags_s6;

	logic [NW-1:0]        num;
	logic [F:0]           q;
	logic [F:0]           n_full;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u2_s5    <= (2 * F)'(u_s4) * (2 * F)'(u_s4);
			y_s5     <= y_s4;
			flags_s5 <= flags_s4;
		end
	end

	// floor(num / 2^(F+1)) lies in [ONE, 1.5*ONE+2]; keep it offset by ONE
	assign num    = K_NUM - NW'(u2_s5);
	assign q      = num[NW-1:F+1];
	assign n_full = q - ONE_Q + REM_Q;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s6     <= n_full[F-1:0];
			y_s6     <= y_s5;
			flags_s6 <= flags_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			nm_s7    <= (2 * F)'(n_s6) * (2 * F)'(RECIP);
			y_s7     <= y_s6;
			flags_s7 <= flags_s6;
		end
	end

endmodule
